/* design/ntb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntb_pkg
// Shared types and constants of the NTC Beta thermometer.
// ----------------------------------------------------------------------------
package ntb_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUPPLY = 3'd0,
		CFG_ADC_REF = 3'd1,
		CFG_SERIES = 3'd2,
		CFG_NOMINAL = 3'd3,
		CFG_BETA = 3'd4
	} cfg_idx_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVER = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	// shared divider: numerator and denominator widths
	localparam int DIV_NW = 52;
	localparam int DIV_DW = 38;
	localparam int DIV_CW = 6;

	// log2 unit: operand width and Q16 result width
	localparam int LOG_W = 34;
	localparam int LOG_RW = 22;
	localparam int LOG_IPW = 6;

	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQ
	} log_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_VOLT,
		S_CHK,
		S_DIV1,
		S_CHKR,
		S_LOG1,
		S_LOG2,
		S_LN,
		S_LNR,
		S_DEN,
		S_DENC,
		S_NUM,
		S_DIV2,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

/* design/ntb_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntb_div
	import ntb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] numer,
	input  wire logic [DIV_DW-1:0] denom,
	output logic                   done,
	output logic [DIV_NW-1:0]      quot
);

	logic              busy_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= busy_q && (cnt_q == DIV_CW'(DIV_NW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= denom;
			quo_q <= numer;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign quot = quo_q;

endmodule
`default_nettype wire

/* design/ntb_log2.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntb_log2
// Base-2 logarithm in Q16: leading-one search by shifting, then sixteen
// mantissa squarings, one per cycle.
// ----------------------------------------------------------------------------
module ntb_log2
	import ntb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [LOG_W-1:0] x,
	output logic                  done,
	output logic [LOG_RW-1:0]     result
);

	log_state_t         state_q, state_d;
	logic [LOG_W-1:0]   m_q;
	logic [LOG_IPW-1:0] ip_q;
	logic [30:0]        sq_q;
	logic [15:0]        frac_q;
	logic [3:0]         it_q;
	logic [61:0]        prod;
	logic [31:0]        sqn;

	assign prod = sq_q * sq_q;
	assign sqn = prod[61:30];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= LG_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		done = 1'b0;
		unique case (state_q)
			LG_IDLE: begin
				if (start)
					state_d = LG_NORM;
			end
			LG_NORM: begin
				if (m_q[LOG_W-1])
					state_d = LG_SQ;
			end
			LG_SQ: begin
				if (it_q == 4'd15) begin
					state_d = LG_IDLE;
					done = 1'b1;
				end
			end
			default: state_d = LG_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LG_IDLE: begin
				m_q <= x;
				ip_q <= LOG_IPW'(LOG_W - 1);
				it_q <= '0;
				frac_q <= '0;
			end
			LG_NORM: begin
				if (m_q[LOG_W-1]) begin
					sq_q <= m_q[LOG_W-1 -: 31];
				end else begin
					m_q <= {m_q[LOG_W-2:0], 1'b0};
					ip_q <= ip_q - 1'b1;
				end
			end
			LG_SQ: begin
				it_q <= it_q + 1'b1;
				frac_q <= {frac_q[14:0], sqn[31]};
				sq_q <= sqn[31] ? sqn[31:1] : sqn[30:0];
			end
			default: it_q <= '0;
		endcase
	end

	assign result = {ip_q, frac_q[14:0], sqn[31]};

endmodule
`default_nettype wire

/* design/ntb_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntb_core
// Sequencer for the conversion of one mean code to temperature, driving the
// shared divider and log2 unit.
// ----------------------------------------------------------------------------
module ntb_core
	import ntb_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [11:0] mean,
	input  wire logic [12:0] supply,
	input  wire logic [12:0] adc_ref,
	input  wire logic [19:0] series,
	input  wire logic [19:0] nominal,
	input  wire logic [13:0] beta,
	output logic             busy,
	output logic             fin,
	output logic signed [14:0] temp,
	output logic [1:0]       stat
);

	state_t state_q, state_d;

	logic [24:0]        v_q;
	logic [32:0]        r_q;
	logic [LOG_RW-1:0]  lgr_q;
	logic signed [22:0] d_q;
	logic [51:0]        mag_q;
	logic signed [22:0] l_q;
	logic [36:0]        t1_q;
	logic signed [39:0] den_q;
	logic [28:0]        num1_q;
	logic [51:0]        num_q;
	logic signed [14:0] temp_q;
	logic [1:0]         stat_q;

	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quot;
	logic [DIV_DW-1:0] div_den;
	logic              log_start, log_done;
	logic [LOG_W-1:0]  log_x;
	logic [LOG_RW-1:0] log_res;
	logic [21:0]       dabs;
	logic [21:0]       lmag;

	assign dabs = d_q[22] ? 22'(-d_q) : d_q[21:0];
	assign lmag = 22'((mag_q + 52'(1 << 29)) >> 30);

	ntb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(div_num),
		.denom(div_den), .done(div_done), .quot(div_quot)
	);

	ntb_log2 u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start), .x(log_x),
		.done(log_done), .result(log_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		div_num = DIV_NW'(v_q[12:0]) * DIV_NW'(series);
		div_den = DIV_DW'(13'(supply - v_q[12:0]));
		log_start = 1'b0;
		log_x = LOG_W'(r_q);
		fin = 1'b0;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_VOLT;
			S_VOLT: state_d = S_CHK;
			S_CHK: begin
				if (v_q >= 25'(supply) || v_q == '0) begin
					state_d = S_DONE;
				end else begin
					div_start = 1'b1;
					state_d = S_DIV1;
				end
			end
			S_DIV1: if (div_done) state_d = S_CHKR;
			S_CHKR: begin
				if (r_q == '0 || nominal == '0) begin
					state_d = S_DONE;
				end else begin
					log_start = 1'b1;
					state_d = S_LOG1;
				end
			end
			S_LOG1: if (log_done) state_d = S_LOG2;
			S_LOG2: begin
				log_start = 1'b1;
				log_x = LOG_W'(nominal);
				if (log_done)
					state_d = S_LN;
			end
			S_LN: state_d = S_LNR;
			S_LNR: state_d = S_DEN;
			S_DEN: state_d = S_DENC;
			S_DENC: state_d = (den_q <= 0) ? S_DONE : S_NUM;
			S_NUM: begin
				div_start = 1'b1;
				div_num = num_q + 52'(den_q[DIV_DW-1:1]);
				div_den = den_q[DIV_DW-1:0];
				state_d = S_DIV2;
			end
			S_DIV2: if (div_done) state_d = S_DONE;
			S_DONE: begin
				fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				temp_q <= '0;
				stat_q <= ST_OK;
			end
			S_VOLT: v_q <= 25'((25'(mean) * 25'(adc_ref)) >> ADC_BITS);
			S_CHK: begin
				if (v_q >= 25'(supply))
					stat_q <= ST_OVER;
				else if (v_q == '0)
					stat_q <= ST_ZERO;
			end
			S_DIV1: r_q <= div_quot[32:0];
			S_CHKR: begin
				if (r_q == '0) begin
					stat_q <= ST_ZERO;
				end else if (nominal == '0) begin
					stat_q <= ST_SAT;
					temp_q <= -15'sd4000;
				end
			end
			S_LOG1: if (log_done) lgr_q <= log_res;
			S_LOG2: d_q <= $signed({1'b0, lgr_q}) - $signed({1'b0, log_res});
			S_LN: mag_q <= dabs * LN2_Q30;
			S_LNR: begin
				l_q <= d_q[22] ? -$signed({1'b0, lmag}) : $signed({1'b0, lmag});
				t1_q <= beta * 23'd6553600;
			end
			S_DEN: begin
				den_q <= $signed({3'b0, t1_q}) + 40'(l_q) * 40'sd29815;
				num1_q <= beta * 15'd29815;
			end
			S_DENC: begin
				num_q <= num1_q * 23'd6553600;
				if (den_q <= 0) begin
					stat_q <= ST_SAT;
					temp_q <= 15'sd15000;
				end
			end
			S_DIV2: begin
				if (div_done) begin
					if (div_quot < 52'd23315) begin
						stat_q <= ST_SAT;
						temp_q <= -15'sd4000;
					end else if (div_quot > 52'd42315) begin
						stat_q <= ST_SAT;
						temp_q <= 15'sd15000;
					end else begin
						temp_q <= 15'($signed({1'b0, div_quot[15:0]}) - 17'sd27315);
					end
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign temp = temp_q;
	assign stat = stat_q;

endmodule
`default_nettype wire

/* design/ntc_beta_thermometer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntc_beta_thermometer_top
// NTC thermistor thermometer using the Beta equation.
// ----------------------------------------------------------------------------
// Samples are taken in pairs, one per cycle while idle; the larger of each
// pair is summed and every 2*PAIRS samples one result transaction is made.
// The conversion keeps in_ready low while it runs: two passes through the
// bit-serial divider, two runs of the log2 unit (a leading-one search by
// shifting, a load step and 16 squarings each, plus a start step for the
// second run), and a few sequencing steps. Early faults finish sooner.
// A finished result waits in the output register and samples
// keep being accepted meanwhile; a further finished result is parked in a
// holding register, and in_ready stays low until it has moved out.
// ----------------------------------------------------------------------------
module ntc_beta_thermometer_top
	import ntb_pkg::*;
#(
	parameter int PAIRS = 3,
	parameter int ADC_BITS = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [11:0]           adc_sample,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [14:0]         temp_centi_c,
	output logic [11:0]                mean_code,
	output logic [1:0]                 status,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(2 * PAIRS);
	localparam int SUM_W = 12 + $clog2(PAIRS + 1);
	localparam logic [11:0] SMASK = 12'((32'd1 << ADC_BITS) - 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(2 * PAIRS - 1);
	// mean by reciprocal multiplication, exact over the whole sum range
	localparam int RCP_SH = SUM_W + $clog2(PAIRS);
	localparam int RCP_W = RCP_SH + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH) + PAIRS - 1) / PAIRS);

	logic [12:0] supply_q, adc_ref_q;
	logic [19:0] series_q, nominal_q;
	logic [13:0] beta_q;

	logic [CNT_W-1:0] cnt_q;
	logic [11:0]      first_q;
	logic [SUM_W-1:0] sum_q;
	logic [11:0]      mean_q;
	logic             go_q;

	logic [11:0]      s, mx;
	logic [SUM_W-1:0] total;
	logic [PROD_W-1:0] mean_prod;
	logic             core_busy, core_fin, hold;
	logic signed [14:0] core_temp;
	logic [1:0]       core_stat;

	logic pend_q;
	logic signed [14:0] ptemp_q;
	logic [1:0]  pstat_q;
	logic [11:0] pmean_q;

	assign cfg_ready = 1'b1;
	assign s = adc_sample & SMASK;
	assign mx = (first_q >= s) ? first_q : s;
	assign total = sum_q + SUM_W'(mx);
	assign mean_prod = PROD_W'(total) * PROD_W'(RCP);
	assign in_ready = !core_busy && !go_q && !pend_q;
	assign hold = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 13'd3300;
			adc_ref_q <= 13'd3600;
			series_q <= 20'd100000;
			nominal_q <= 20'd100000;
			beta_q <= 14'd4250;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SUPPLY: supply_q <= cfg_data[12:0];
				CFG_ADC_REF: adc_ref_q <= cfg_data[12:0];
				CFG_SERIES: series_q <= cfg_data;
				CFG_NOMINAL: nominal_q <= cfg_data;
				CFG_BETA: beta_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			first_q <= '0;
			sum_q <= '0;
			go_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (in_valid && in_ready) begin
				if (!cnt_q[0]) begin
					first_q <= s;
					cnt_q <= cnt_q + 1'b1;
				end else if (cnt_q == LAST) begin
					mean_q <= 12'(mean_prod >> RCP_SH);
					cnt_q <= '0;
					sum_q <= '0;
					first_q <= '0;
					go_q <= 1'b1;
				end else begin
					sum_q <= total;
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	ntb_core #(.ADC_BITS(ADC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(go_q), .mean(mean_q),
		.supply(supply_q), .adc_ref(adc_ref_q), .series(series_q),
		.nominal(nominal_q), .beta(beta_q), .busy(core_busy),
		.fin(core_fin), .temp(core_temp), .stat(core_stat)
	);

	// core_fin may only be taken when the output register is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (core_fin && hold) begin
				pend_q <= 1'b1;
			end else if (core_fin || (pend_q && !hold)) begin
				out_valid <= 1'b1;
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (core_fin) begin
			ptemp_q <= core_temp;
			pstat_q <= core_stat;
			pmean_q <= mean_q;
		end
		if (core_fin && !hold) begin
			temp_centi_c <= core_temp;
			status <= core_stat;
			mean_code <= mean_q;
		end else if (pend_q && !hold) begin
			temp_centi_c <= ptemp_q;
			status <= pstat_q;
			mean_code <= pmean_q;
		end
	end

endmodule
`default_nettype wire

/* tb/ntb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntb_checker
// Watches the sample, result and register channels of the NTC Beta
// thermometer, predicts each result from the accepted samples and the
// current register values, and compares every result transaction.
// ----------------------------------------------------------------------------
module ntb_checker
	import ntb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic [11:0]           adc_sample,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic signed [14:0]    temp_centi_c,
	input  wire logic [11:0]           mean_code,
	input  wire logic [1:0]            status,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         errors,
	output int                         pending
);

	typedef struct packed {
		logic signed [14:0] temp;
		logic [11:0]        mean;
		logic [1:0]         st;
	} reading_t;

	localparam int NUM_PAIRS = 3;

	reading_t    readings_due[$];
	logic [12:0] supply, adc_ref;
	logic [19:0] series, nominal;
	logic [13:0] beta;
	logic [2:0]  position;
	logic [11:0] first_of_pair;
	logic [13:0] maxima_sum;

	function automatic longint log2_fix16(longint unsigned x);
		int          ip;
		longint unsigned m;
		longint      frac;
		ip = 63;
		frac = 0;
		while (ip > 0 && x[ip] == 1'b0)
			ip--;
		m = (ip >= 30) ? (x >> (ip - 30)) : (x << (30 - ip));
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return longint'(ip) * 65536 + frac;
	endfunction

	function automatic reading_t beta_temperature(logic [11:0] mean);
		reading_t        rd;
		longint unsigned v, r, mag, lmag, num;
		longint          d, l, den, tc;
		rd.mean = mean;
		rd.temp = '0;
		rd.st = ST_OK;
		v = (longint'(mean) * adc_ref) >> 12;
		if (v >= supply) begin
			rd.st = ST_OVER;
			return rd;
		end
		if (v == 0) begin
			rd.st = ST_ZERO;
			return rd;
		end
		r = (v * series) / (longint'(supply) - v);
		if (r == 0) begin
			rd.st = ST_ZERO;
			return rd;
		end
		if (nominal == 0) begin
			rd.temp = -15'sd4000;
			rd.st = ST_SAT;
			return rd;
		end
		d = log2_fix16(r) - log2_fix16(nominal);
		mag = longint'(d < 0 ? -d : d) * 744261118;
		lmag = (mag + (64'd1 << 29)) >> 30;
		l = (d < 0) ? -longint'(lmag) : longint'(lmag);
		den = longint'(beta) * 6553600 + 29815 * l;
		if (den <= 0) begin
			rd.temp = 15'sd15000;
			rd.st = ST_SAT;
			return rd;
		end
		num = longint'(beta) * 29815 * 6553600;
		tc = longint'((num + longint'(den) / 2) / longint'(den)) - 27315;
		if (tc < -4000) begin
			rd.temp = -15'sd4000;
			rd.st = ST_SAT;
		end else if (tc > 15000) begin
			rd.temp = 15'sd15000;
			rd.st = ST_SAT;
		end else begin
			rd.temp = tc[14:0];
		end
		return rd;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	initial errors = 0;
	initial pending = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply <= 13'd3300;
			adc_ref <= 13'd3600;
			series <= 20'd100000;
			nominal <= 20'd100000;
			beta <= 14'd4250;
			position <= '0;
			first_of_pair <= '0;
			maxima_sum <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SUPPLY: supply <= cfg_data[12:0];
					CFG_ADC_REF: adc_ref <= cfg_data[12:0];
					CFG_SERIES: series <= cfg_data;
					CFG_NOMINAL: nominal <= cfg_data;
					CFG_BETA: beta <= cfg_data[13:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (!position[0]) begin
					first_of_pair <= adc_sample;
					position <= position + 1'b1;
				end else begin
					logic [13:0] sum;
					sum = maxima_sum + ((first_of_pair >= adc_sample) ? first_of_pair
						: adc_sample);
					if (position + 1 >= 2 * NUM_PAIRS) begin
						readings_due.push_back(beta_temperature(12'(sum / NUM_PAIRS)));
						position <= '0;
						maxima_sum <= '0;
						first_of_pair <= '0;
					end else begin
						maxima_sum <= sum;
						position <= position + 1'b1;
					end
				end
			end
			if (out_valid && out_ready) begin
				if (readings_due.size() == 0) begin
					report("unexpected result", mean_code, -1);
				end else begin
					reading_t want;
					want = readings_due.pop_front();
					if (temp_centi_c !== want.temp)
						report("temp_centi_c", temp_centi_c, want.temp);
					if (mean_code !== want.mean)
						report("mean_code", mean_code, want.mean);
					if (status !== want.st)
						report("status", status, want.st);
				end
			end
		end
		pending = readings_due.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression of the NTC Beta thermometer: directed extreme samples, then
// random samples over several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import ntb_pkg::*;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  in_valid = 0;
	logic                  in_ready;
	logic [11:0]           adc_sample = '0;
	logic                  out_valid;
	logic                  out_ready = 0;
	logic signed [14:0]    temp_centi_c;
	logic [11:0]           mean_code;
	logic [1:0]            status;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SUPPLY;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    errors, pending;
	int                    send_idle_pct = 0;
	int                    recv_stall_pct = 0;

	always #2 clk = ~clk;

	ntc_beta_thermometer_top dut (.*);

	ntb_checker chk (.*);

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic send_sample(logic [11:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		adc_sample <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic load_setting(int sel);
		int s, a, r, n, b;
		case (sel)
			0: begin s = 3300; a = 3600; r = 100000; n = 100000; b = 4250; end
			1: begin s = 1000; a = 1000; r = 1000; n = 1000; b = 1000; end
			2: begin s = 5000; a = 5000; r = 1000000; n = 1000000; b = 10000; end
			3: begin s = 1000; a = 5000; r = 1000000; n = 1000; b = 10000; end
			4: begin s = 0; a = 8191; r = 0; n = 1048575; b = 16383; end
			5: begin s = 8191; a = 3600; r = 1048575; n = 0; b = 0; end
			default: begin
				s = $urandom_range(5000, 1000);
				a = $urandom_range(5000, 1000);
				r = $urandom_range(1000000, 1000);
				n = $urandom_range(1000000, 1000);
				b = $urandom_range(10000, 1000);
			end
		endcase
		write_reg(CFG_SUPPLY, CFG_DATA_W'(s));
		write_reg(CFG_ADC_REF, CFG_DATA_W'(a));
		write_reg(CFG_SERIES, CFG_DATA_W'(r));
		write_reg(CFG_NOMINAL, CFG_DATA_W'(n));
		write_reg(CFG_BETA, CFG_DATA_W'(b));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#400000000;
		$display("ntc_beta_thermometer_top regression: fail");
		$finish;
	end

	initial begin
		logic [11:0] directed[$];
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0,
			12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
			12'd1, 12'd2048, 12'd2048, 12'd2048, 12'hAAA, 12'h555,
			12'd3000, 12'd10, 12'd10, 12'd3000, 12'd2000, 12'd2000};
		foreach (directed[i])
			send_sample(directed[i]);
		settle();
		for (int ph = 0; ph < 16; ph++) begin
			load_setting(ph < 6 ? ph : 6);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 71; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 71; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase
			for (int k = 0; k < 48; k++) begin
				if ($urandom_range(3) == 0)
					send_sample(12'($urandom_range(4095)));
				else
					send_sample(12'($urandom_range(3900, 300)));
			end
			settle();
		end
		recv_stall_pct = 0;
		if (errors == 0)
			$display("ntc_beta_thermometer_top regression: pass");
		else
			$display("ntc_beta_thermometer_top regression: fail");
		$finish;
	end

endmodule
